/* rtl/core/point_to_segment_distance_macros.svh */
`ifndef POINT_TO_SEGMENT_DISTANCE_MACROS_SVH
`define POINT_TO_SEGMENT_DISTANCE_MACROS_SVH

// clocked check, off while reset is asserted
`define PTSD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// clocked check that also runs during reset
`define PTSD_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* rtl/core/ptsd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package ptsd_pkg;

    // output width and radicand width of the root
    localparam int DIST_BITS = 25;
    localparam int ROOT_BITS = 2 * DIST_BITS;

    // register stages ahead of the divider
    localparam int FRONT_STAGES = 7;

    // start to strobe, in cycles
    localparam int PTSD_LATENCY = FRONT_STAGES + ROOT_BITS + DIST_BITS + 1;

    typedef struct packed {
        logic valid;
        logic ep;   // endpoint case
        logic sat;  // distance overflows the output
    } t_tag;

endpackage
`default_nettype wire

/* rtl/core/ptsd_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module ptsd_front #(
    parameter int COORD_BITS     = 16,
    parameter int DIST_FRAC_BITS = 8,
    parameter int W_REM          = 80,
    parameter int W_DEN          = 33
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    input  wire logic [COORD_BITS-1:0] i_px,
    input  wire logic [COORD_BITS-1:0] i_py,
    input  wire logic [COORD_BITS-1:0] i_ax,
    input  wire logic [COORD_BITS-1:0] i_ay,
    input  wire logic [COORD_BITS-1:0] i_bx,
    input  wire logic [COORD_BITS-1:0] i_by,
    output logic      [W_REM-1:0]      o_num,
    output logic      [W_DEN-1:0]      o_den,
    output ptsd_pkg::t_tag             o_tag
);
    import ptsd_pkg::*;

    localparam int WDF = COORD_BITS + 1;
    localparam int WP  = 2 * COORD_BITS + 2;
    localparam int WS  = 2 * COORD_BITS + 3;
    localparam int WM  = 2 * COORD_BITS + 1;
    localparam int H   = COORD_BITS + 1;
    localparam int WL  = WM - H;
    localparam int WQ  = 2 * WM;

    // stage 1: differences
    logic signed [WDF-1:0] r1_dx, r1_dy, r1_ux, r1_uy, r1_vx, r1_vy;
    logic                  r1_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else begin
            r1_v <= i_valid;
        end
        r1_dx <= $signed({i_bx[COORD_BITS-1], i_bx}) - $signed({i_ax[COORD_BITS-1], i_ax});
        r1_dy <= $signed({i_by[COORD_BITS-1], i_by}) - $signed({i_ay[COORD_BITS-1], i_ay});
        r1_ux <= $signed({i_px[COORD_BITS-1], i_px}) - $signed({i_ax[COORD_BITS-1], i_ax});
        r1_uy <= $signed({i_py[COORD_BITS-1], i_py}) - $signed({i_ay[COORD_BITS-1], i_ay});
        r1_vx <= $signed({i_px[COORD_BITS-1], i_px}) - $signed({i_bx[COORD_BITS-1], i_bx});
        r1_vy <= $signed({i_py[COORD_BITS-1], i_py}) - $signed({i_by[COORD_BITS-1], i_by});
    end

    // stage 2: products
    logic signed [WP-1:0] r2_dxdx, r2_dydy, r2_uxdx, r2_uydy, r2_uxdy, r2_uydx;
    logic signed [WP-1:0] r2_uxux, r2_uyuy, r2_vxvx, r2_vyvy;
    logic                 r2_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else begin
            r2_v <= r1_v;
        end
        r2_dxdx <= r1_dx * r1_dx;
        r2_dydy <= r1_dy * r1_dy;
        r2_uxdx <= r1_ux * r1_dx;
        r2_uydy <= r1_uy * r1_dy;
        r2_uxdy <= r1_ux * r1_dy;
        r2_uydx <= r1_uy * r1_dx;
        r2_uxux <= r1_ux * r1_ux;
        r2_uyuy <= r1_uy * r1_uy;
        r2_vxvx <= r1_vx * r1_vx;
        r2_vyvy <= r1_vy * r1_vy;
    end

    // stage 3: length, projection, cross product, endpoint distances
    logic signed [WS-1:0] r3_len2, r3_t, r3_cross, r3_da, r3_db;
    logic                 r3_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else begin
            r3_v <= r2_v;
        end
        r3_len2  <= WS'(r2_dxdx) + WS'(r2_dydy);
        r3_t     <= WS'(r2_uxdx) + WS'(r2_uydy);
        r3_cross <= WS'(r2_uxdy) - WS'(r2_uydx);
        r3_da    <= WS'(r2_uxux) + WS'(r2_uyuy);
        r3_db    <= WS'(r2_vxvx) + WS'(r2_vyvy);
    end

    // stage 4: case decision, magnitude, nearer endpoint
    logic                 on_seg;
    logic signed [WS-1:0] cross_abs;
    logic signed [WS-1:0] dm;

    always_comb begin
        on_seg    = (r3_len2 != '0) && !r3_t[WS-1] && (r3_t <= r3_len2);
        cross_abs = r3_cross[WS-1] ? -r3_cross : r3_cross;
        dm        = (r3_db < r3_da) ? r3_db : r3_da;
    end

    logic [WM-1:0] r4_mag, r4_len2, r4_dm;
    logic          r4_v, r4_ep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else begin
            r4_v <= r3_v;
        end
        r4_ep   <= !on_seg;
        r4_mag  <= cross_abs[WM-1:0];
        r4_len2 <= r3_len2[WM-1:0];
        r4_dm   <= dm[WM-1:0];
    end

    // stage 5: square of the cross magnitude as partial products
    logic [WL-1:0]    mh;
    logic [H-1:0]     ml;
    logic [2*WL-1:0]  r5_hh;
    logic [WL+H-1:0]  r5_hl;
    logic [2*H-1:0]   r5_ll;
    logic [WM-1:0]    r5_len2, r5_dm;
    logic             r5_v, r5_ep;

    assign mh = r4_mag[WM-1:H];
    assign ml = r4_mag[H-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else begin
            r5_v <= r4_v;
        end
        r5_hh   <= mh * mh;
        r5_hl   <= mh * ml;
        r5_ll   <= ml * ml;
        r5_ep   <= r4_ep;
        r5_len2 <= r4_len2;
        r5_dm   <= r4_dm;
    end

    // stage 6: sum of partial products
    logic [WQ-1:0] r6_sq;
    logic [WM-1:0] r6_len2, r6_dm;
    logic          r6_v, r6_ep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else begin
            r6_v <= r5_v;
        end
        r6_sq   <= (WQ'(r5_hh) << (2 * H)) + (WQ'(r5_hl) << (H + 1)) + WQ'(r5_ll);
        r6_ep   <= r5_ep;
        r6_len2 <= r5_len2;
        r6_dm   <= r5_dm;
    end

    // stage 7: dividend and divisor; endpoint case divides by one
    logic [W_REM-1:0] num;
    logic [W_DEN-1:0] den;
    logic             sat;

    always_comb begin
        num = r6_ep ? (W_REM'(r6_dm) << (2 * DIST_FRAC_BITS))
                    : (W_REM'(r6_sq) << (2 * DIST_FRAC_BITS));
        den = r6_ep ? W_DEN'(1) : W_DEN'(r6_len2);
        sat = num >= (W_REM'(den) << ROOT_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_tag <= '0;
        end else begin
            o_tag.valid <= r6_v;
            o_tag.ep    <= r6_ep;
            o_tag.sat   <= sat;
        end
        o_num <= num;
        o_den <= den;
    end

endmodule
`default_nettype wire

/* rtl/core/ptsd_div_stage.sv */
`timescale 1ns / 1ps
`default_nettype none
module ptsd_div_stage #(
    parameter int W_REM = 80,
    parameter int W_DEN = 33,
    parameter int BIT   = 0
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [W_REM-1:0]              i_rem,
    input  wire logic [W_DEN-1:0]              i_den,
    input  wire logic [ptsd_pkg::ROOT_BITS-1:0] i_quo,
    input  wire ptsd_pkg::t_tag                i_tag,
    output logic      [W_REM-1:0]              o_rem,
    output logic      [W_DEN-1:0]              o_den,
    output logic      [ptsd_pkg::ROOT_BITS-1:0] o_quo,
    output ptsd_pkg::t_tag                     o_tag
);
    import ptsd_pkg::*;

    logic [W_REM-1:0] trial;
    logic             ge;

    // restoring step for one quotient bit
    always_comb begin
        trial = W_REM'(i_den) << BIT;
        ge    = i_rem >= trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_tag <= '0;
        end else begin
            o_tag <= i_tag;
        end
        o_rem <= ge ? (i_rem - trial) : i_rem;
        o_den <= i_den;
        o_quo <= i_quo | (ROOT_BITS'(ge) << BIT);
    end

endmodule
`default_nettype wire

/* rtl/core/ptsd_sqrt_stage.sv */
`timescale 1ns / 1ps
`default_nettype none
module ptsd_sqrt_stage #(
    parameter int BIT = 0
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic [ptsd_pkg::ROOT_BITS:0]    i_rem,
    input  wire logic [ptsd_pkg::DIST_BITS-1:0]  i_res,
    input  wire ptsd_pkg::t_tag                  i_tag,
    output logic      [ptsd_pkg::ROOT_BITS:0]    o_rem,
    output logic      [ptsd_pkg::DIST_BITS-1:0]  o_res,
    output ptsd_pkg::t_tag                       o_tag
);
    import ptsd_pkg::*;

    localparam int WRT = ROOT_BITS + 1;

    logic [WRT-1:0] trial;
    logic           ge;

    // rem holds x - res^2; try setting this bit of the root
    always_comb begin
        trial = (WRT'(i_res) << (BIT + 1)) + (WRT'(1) << (2 * BIT));
        ge    = i_rem >= trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_tag <= '0;
        end else begin
            o_tag <= i_tag;
        end
        o_rem <= ge ? (i_rem - trial) : i_rem;
        o_res <= i_res | (DIST_BITS'(ge) << BIT);
    end

endmodule
`default_nettype wire

/* rtl/core/point_to_segment_distance.sv */
//  channel  | signals                                         | dir
//  ---------+-------------------------------------------------+-----
//  command  | start, busy, i_point_*, i_start_*, i_end_*      | in
//  result   | o_valid, o_dist_q8, o_used_endpoint             | out
//
//  One word is taken in every cycle; busy is always low.
//  Each word's result strobes out after 7 front stages, 50 divider stages,
//  25 root stages and 1 output register.
//  The latency is set by the one-bit-per-stage divider and square root.
//  Synchronous active-low reset empties the pipeline; there is no clearing pass.
//  Nothing stalls: the receiver cannot hold results off.
`timescale 1ns / 1ps
`default_nettype none
module point_to_segment_distance #(
    parameter int COORD_BITS     = 16,
    parameter int DIST_FRAC_BITS = 8
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [COORD_BITS-1:0]          i_point_x,
    input  wire logic [COORD_BITS-1:0]          i_point_y,
    input  wire logic [COORD_BITS-1:0]          i_start_x,
    input  wire logic [COORD_BITS-1:0]          i_start_y,
    input  wire logic [COORD_BITS-1:0]          i_end_x,
    input  wire logic [COORD_BITS-1:0]          i_end_y,
    output logic                                o_valid,
    output logic [ptsd_pkg::DIST_BITS-1:0]      o_dist_q8,
    output logic                                o_used_endpoint
);
    import ptsd_pkg::*;

    // dividend must hold the scaled square and the divisor shifted past
    // the quotient range
    localparam int W_NUM = 4 * COORD_BITS + 2 + 2 * DIST_FRAC_BITS;
    localparam int W_DEN = 2 * COORD_BITS + 1;
    localparam int W_CMP = W_DEN + ROOT_BITS + 1;
    localparam int W_REM = (W_NUM > W_CMP) ? W_NUM : W_CMP;

    assign busy = 1'b0;

    // front end: differences, products, case select, cross square
    logic [W_REM-1:0] d_rem [0:ROOT_BITS];
    logic [W_DEN-1:0] d_den [0:ROOT_BITS];
    logic [ROOT_BITS-1:0] d_quo [0:ROOT_BITS];
    t_tag             d_tag [0:ROOT_BITS];

    ptsd_front #(
        .COORD_BITS     (COORD_BITS),
        .DIST_FRAC_BITS (DIST_FRAC_BITS),
        .W_REM          (W_REM),
        .W_DEN          (W_DEN)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start),
        .i_px    (i_point_x),
        .i_py    (i_point_y),
        .i_ax    (i_start_x),
        .i_ay    (i_start_y),
        .i_bx    (i_end_x),
        .i_by    (i_end_y),
        .o_num   (d_rem[0]),
        .o_den   (d_den[0]),
        .o_tag   (d_tag[0])
    );

    assign d_quo[0] = '0;

    // divider: quotient bits from msb down, one per stage
    for (genvar g = 0; g < ROOT_BITS; g++) begin : g_div
        ptsd_div_stage #(
            .W_REM (W_REM),
            .W_DEN (W_DEN),
            .BIT   (ROOT_BITS - 1 - g)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_rem   (d_rem[g]),
            .i_den   (d_den[g]),
            .i_quo   (d_quo[g]),
            .i_tag   (d_tag[g]),
            .o_rem   (d_rem[g+1]),
            .o_den   (d_den[g+1]),
            .o_quo   (d_quo[g+1]),
            .o_tag   (d_tag[g+1])
        );
    end

    // square root: root bits from msb down, one per stage
    logic [ROOT_BITS:0]   s_rem [0:DIST_BITS];
    logic [DIST_BITS-1:0] s_res [0:DIST_BITS];
    t_tag                 s_tag [0:DIST_BITS];

    assign s_rem[0] = {1'b0, d_quo[ROOT_BITS]};
    assign s_res[0] = '0;
    assign s_tag[0] = d_tag[ROOT_BITS];

    for (genvar g = 0; g < DIST_BITS; g++) begin : g_root
        ptsd_sqrt_stage #(
            .BIT (DIST_BITS - 1 - g)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_rem   (s_rem[g]),
            .i_res   (s_res[g]),
            .i_tag   (s_tag[g]),
            .o_rem   (s_rem[g+1]),
            .o_res   (s_res[g+1]),
            .o_tag   (s_tag[g+1])
        );
    end

    // output register with saturation
    logic                 r_valid, r_used;
    logic [DIST_BITS-1:0] r_dist;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= s_tag[DIST_BITS].valid;
        end
        r_dist <= s_tag[DIST_BITS].sat ? '1 : s_res[DIST_BITS];
        r_used <= s_tag[DIST_BITS].ep;
    end

    assign o_valid         = r_valid;
    assign o_dist_q8       = r_dist;
    assign o_used_endpoint = r_used;

endmodule
`default_nettype wire

/* rtl/core/ptsd_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "point_to_segment_distance_macros.svh"
module ptsd_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic o_valid
);
    import ptsd_pkg::*;

    // pipeline never pushes back
    `PTSD_ASSERT(a_never_busy, !busy, "busy raised")
    // reset empties the output register
    `PTSD_ASSERT_RST(a_rst_clears, !i_rst_n |=> !o_valid, "strobe after reset")
    // every strobe traces back to an accepted word
    `PTSD_ASSERT(a_fixed_latency, o_valid |-> $past(start && !busy, PTSD_LATENCY), "spurious strobe")

endmodule

bind point_to_segment_distance ptsd_checker u_ptsd_checker (.*);
`default_nettype wire

/* sim/point_to_segment_distance_tb.sv */
`timescale 1ns / 1ps
module point_to_segment_distance_tb;

    // geometry of one query word
    typedef struct {
        logic [15:0] px, py, ax, ay, bx, by;
    } seg_query_t;

    // expected answer for one query
    typedef struct {
        logic [24:0] dist_val;
        logic        ep;
    } seg_answer_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [15:0] i_point_x, i_point_y, i_start_x, i_start_y, i_end_x, i_end_y;
    logic        o_valid;
    logic [24:0] o_dist_q8;
    logic        o_used_endpoint;

    seg_query_t  query_q[$];
    seg_answer_t answer_q[$];
    int          fail_count;
    int          cycle_count;
    int          idle_pct;      // chance in percent that the sender skips a cycle
    bit          stim_done;

    localparam int LIMIT_CYCLES = 400000;

    point_to_segment_distance DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_point_x      (i_point_x),
        .i_point_y      (i_point_y),
        .i_start_x      (i_start_x),
        .i_start_y      (i_start_y),
        .i_end_x        (i_end_x),
        .i_end_y        (i_end_y),
        .o_valid        (o_valid),
        .o_dist_q8      (o_dist_q8),
        .o_used_endpoint(o_used_endpoint)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // floor(sqrt(x)), saturated to the 25-bit output
    function automatic logic [24:0] isqrt_sat(logic [127:0] x);
        logic [63:0] r;
        logic [63:0] c;
        r = '0;
        if (x >= (128'd1 << 50)) return '1;
        for (int b = 25; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if (c * c <= x[63:0]) r = c;
        end
        return r[24:0];
    endfunction

    // distance from point to segment, exact integer arithmetic
    function automatic seg_answer_t seg_distance(seg_query_t q);
        seg_answer_t a;
        logic signed [127:0] dx, dy, ux, uy, vx, vy, len2, t, cr, da, db;
        logic        [127:0] quo;
        dx = $signed(q.bx) - $signed(q.ax);
        dy = $signed(q.by) - $signed(q.ay);
        ux = $signed(q.px) - $signed(q.ax);
        uy = $signed(q.py) - $signed(q.ay);
        vx = $signed(q.px) - $signed(q.bx);
        vy = $signed(q.py) - $signed(q.by);
        len2 = dx * dx + dy * dy;
        t = ux * dx + uy * dy;
        if (len2 != 0 && t >= 0 && t <= len2) begin
            cr = ux * dy - uy * dx;
            quo = ((cr * cr) << 16) / len2;
            a.dist_val = isqrt_sat(quo);
            a.ep = 1'b0;
        end else begin
            da = ux * ux + uy * uy;
            db = vx * vx + vy * vy;
            a.dist_val = isqrt_sat(((db < da) ? db : da) << 16);
            a.ep = 1'b1;
        end
        return a;
    endfunction

    task automatic push_query(int px, int py, int ax, int ay, int bx, int by);
        seg_query_t q;
        q.px = px[15:0]; q.py = py[15:0];
        q.ax = ax[15:0]; q.ay = ay[15:0];
        q.bx = bx[15:0]; q.by = by[15:0];
        query_q.push_back(q);
    endtask

    task automatic report_mismatch(string what, logic [24:0] got, logic [24:0] want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d",
                 what, got, want, cycle_count);
        fail_count++;
    endtask

    // driver: one word per cycle when not idling; changes at falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (query_q.size() != 0 && !busy &&
                     $urandom_range(99) >= idle_pct) begin
            seg_query_t q;
            q = query_q.pop_front();
            i_point_x <= q.px; i_point_y <= q.py;
            i_start_x <= q.ax; i_start_y <= q.ay;
            i_end_x   <= q.bx; i_end_y   <= q.by;
            answer_q.push_back(seg_distance(q));
            start <= 1'b1;
        end else begin
            start <= 1'b0;
        end
    end

    // monitor: results are sampled at the rising edge
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_valid) begin
            if (answer_q.size() == 0) begin
                report_mismatch("unexpected word", o_dist_q8, 25'd0);
            end else begin
                seg_answer_t a;
                a = answer_q.pop_front();
                if (o_dist_q8 !== a.dist_val)
                    report_mismatch("dist_q8", o_dist_q8, a.dist_val);
                if (o_used_endpoint !== a.ep)
                    report_mismatch("used_endpoint", 25'(o_used_endpoint), 25'(a.ep));
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (cycle_count > LIMIT_CYCLES) begin
            $display("FAIL point_to_segment_distance");
            $finish;
        end
    end

    function automatic int rnd_coord(int span);
        if (span == 0) return int'($urandom_range(65535)) - 32768;
        return int'($urandom_range(2 * span)) - span;
    endfunction

    initial begin
        int n, ax, ay, bx, by, t;
        start = 1'b0;
        i_point_x = '0; i_point_y = '0; i_start_x = '0;
        i_start_y = '0; i_end_x = '0;   i_end_y = '0;
        fail_count = 0;
        cycle_count = 0;
        idle_pct = 0;
        stim_done = 1'b0;
        i_rst_n = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, degenerate segment, foot on either endpoint
        push_query(0, 0, 0, 0, 0, 0);
        push_query(32767, 32767, 32767, 32767, 32767, 32767);
        push_query(-32768, -32768, 32767, 32767, 32767, 32767);
        push_query(32767, -32768, -32768, 32767, -32768, 32767);
        push_query(-32768, 32767, -32768, -32768, 32767, -32768);
        push_query(32767, 32767, -32768, -32768, 32767, -32768);
        push_query(0, 100, 0, 0, 10, 0);        // foot on start
        push_query(10, -100, 0, 0, 10, 0);      // foot on end
        push_query(-1, 5, 0, 0, 10, 0);         // just before start
        push_query(11, 5, 0, 0, 10, 0);         // just past end
        push_query(5, 5, 0, 0, 10, 0);
        push_query(3, 4, 0, 0, 0, 0);
        push_query(0, 0, -32768, 32767, 32767, -32768);
        push_query(32767, 32767, -32768, 32767, 32767, -32768);
        push_query(-32768, -32768, -32768, 32767, 32767, -32768);
        push_query(1, 1, 0, 0, 1, 0);
        push_query(-1, -1, 0, 0, -1, 0);
        push_query(-32768, 0, 32767, 0, 32767, 0);
        push_query(2, 1, 0, 0, 3, 3);

        // random phases; idle percentage set per phase
        for (int phase = 0; phase < 4; phase++) begin
            while (query_q.size() != 0) @(posedge i_clk);
            idle_pct = (phase == 1) ? 62 : (phase == 2) ? 21 : 0;
            for (int k = 0; k < 110; k++) begin
                n = $urandom_range(3);
                t = (n == 0) ? 0 : (n == 1) ? 200 : (n == 2) ? 4000 : 0;
                ax = rnd_coord(t); ay = rnd_coord(t);
                if ($urandom_range(9) == 0) begin
                    bx = ax; by = ay;
                end else begin
                    bx = rnd_coord(t); by = rnd_coord(t);
                end
                push_query(rnd_coord(t), rnd_coord(t), ax, ay, bx, by);
            end
        end

        while (query_q.size() != 0 || answer_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS point_to_segment_distance");
        end else begin
            $display("FAIL point_to_segment_distance");
        end
        $finish;
    end

endmodule
